// ===== rtl/sst_pkg.sv =====
package sst_pkg;

  localparam int unsigned LowMargin = 9830;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgProbThreshold   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgWindowSamples   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMinSilenceLen   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMinSpeechLen    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMaxSpeechLen    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgSplitSilenceLen = 3'd5;

  // window class decided by the front end
  typedef enum logic [1:0] {
    ClsMid  = 2'd0,
    ClsHigh = 2'd1,
    ClsLow  = 2'd2
  } cls_e;

  typedef struct packed {
    logic [15:0] prob_threshold;
    logic [15:0] window_samples;
    logic [23:0] min_silence_len;
    logic [23:0] min_speech_len;
    logic [31:0] max_speech_len;
    logic [23:0] split_silence_len;
  } cfg_t;

  typedef struct packed {
    logic seg_valid;
    logic [31:0] seg_start;
    logic [31:0] seg_end;
    logic speaking;
  } result_t;

endpackage

// ===== rtl/sst_front.sv =====
module sst_front import sst_pkg::*; (
  input  logic [15:0] speech_prob_i,
  input  logic [15:0] prob_threshold_i,
  output cls_e        cls_o
);

  logic [15:0] low_thr;

  // lower threshold saturates at zero
  assign low_thr = (prob_threshold_i >= 16'(LowMargin)) ?
                   (prob_threshold_i - 16'(LowMargin)) : 16'd0;

  always_comb begin
    if (speech_prob_i >= prob_threshold_i) begin
      cls_o = ClsHigh;
    end else if (speech_prob_i < low_thr) begin
      cls_o = ClsLow;
    end else begin
      cls_o = ClsMid;
    end
  end

endmodule

// ===== rtl/sst_fifo.sv =====
module sst_fifo import sst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_en_i,
  input  cls_e wr_cls_i,
  input  logic rd_en_i,
  output cls_e rd_cls_o,
  output logic empty_o,
  output logic full_o
);

  cls_e             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign empty_o  = (cnt_q == '0);
  assign full_o   = (cnt_q == QCntW'(QDepth));
  assign rd_cls_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_en_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en_i && !rd_en_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_en_i && rd_en_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_cls_i;
    end
  end

endmodule

// ===== rtl/sst_back.sv =====
module sst_back import sst_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    q_empty_i,
  input  cls_e    q_cls_i,
  output logic    q_pop_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t res_o
);

  logic [31:0] sample_pos_q, sample_pos_d;
  logic        in_speech_q, in_speech_d;
  logic [31:0] silence_from_q, silence_from_d;
  logic [31:0] last_good_end_q, last_good_end_d;
  logic [31:0] resume_start_q, resume_start_d;
  logic [31:0] cur_start_q, cur_start_d;
  logic        out_valid_q;
  result_t     res_q, res_d;

  logic [31:0] pos_n;
  logic [31:0] sil_n;
  logic [31:0] quiet;
  logic        over_max;

  assign q_pop_o     = !q_empty_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  assign pos_n    = sample_pos_q + 32'(cfg_i.window_samples);
  assign over_max = (pos_n - cur_start_q) > cfg_i.max_speech_len;
  assign sil_n    = (silence_from_q == '0) ? pos_n : silence_from_q;
  assign quiet    = pos_n - sil_n;

  always_comb begin
    sample_pos_d    = pos_n;
    in_speech_d     = in_speech_q;
    silence_from_d  = silence_from_q;
    last_good_end_d = last_good_end_q;
    resume_start_d  = resume_start_q;
    cur_start_d     = cur_start_q;
    res_d           = '0;

    case (q_cls_i)
      ClsHigh: begin
        if (silence_from_q != '0) begin
          silence_from_d = '0;
          if (resume_start_q < last_good_end_q) begin
            resume_start_d = sample_pos_q;
          end
        end
        if (!in_speech_q) begin
          in_speech_d = 1'b1;
          cur_start_d = sample_pos_q;
        end
      end
      default: begin
        if (in_speech_q && over_max) begin
          // forced cut, at the last long pause when there is one
          res_d.seg_valid = 1'b1;
          res_d.seg_start = cur_start_q;
          silence_from_d  = '0;
          last_good_end_d = '0;
          resume_start_d  = '0;
          cur_start_d     = '0;
          if (last_good_end_q != '0) begin
            res_d.seg_end = last_good_end_q;
            if (!(resume_start_q < last_good_end_q)) begin
              cur_start_d = resume_start_q;
            end else begin
              in_speech_d = 1'b0;
            end
          end else begin
            res_d.seg_end = pos_n;
            in_speech_d   = 1'b0;
          end
        end else if (q_cls_i == ClsLow && in_speech_q) begin
          silence_from_d = sil_n;
          if (quiet > 32'(cfg_i.split_silence_len)) begin
            last_good_end_d = sil_n;
          end
          if (quiet >= 32'(cfg_i.min_silence_len) &&
              (sil_n - cur_start_q) > 32'(cfg_i.min_speech_len)) begin
            res_d.seg_valid = 1'b1;
            res_d.seg_start = cur_start_q;
            res_d.seg_end   = sil_n;
            silence_from_d  = '0;
            last_good_end_d = '0;
            resume_start_d  = '0;
            cur_start_d     = '0;
            in_speech_d     = 1'b0;
          end
        end
      end
    endcase
    res_d.speaking = in_speech_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_pos_q    <= '0;
      in_speech_q     <= 1'b0;
      silence_from_q  <= '0;
      last_good_end_q <= '0;
      resume_start_q  <= '0;
      cur_start_q     <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      if (q_pop_o) begin
        sample_pos_q    <= sample_pos_d;
        in_speech_q     <= in_speech_d;
        silence_from_q  <= silence_from_d;
        last_good_end_q <= last_good_end_d;
        resume_start_q  <= resume_start_d;
        cur_start_q     <= cur_start_d;
        out_valid_q     <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_q <= res_d;
    end
  end

endmodule

// ===== rtl/speech_segment_tracker.sv =====
// Speech segment tracker: one speech probability per window in, one result
// per window out, at a sustained rate of one window per clock when neither
// side stalls. A window is classified against the upper and lower
// thresholds as it is accepted and held in a four-entry queue; the segment
// state machine takes one window from the queue each cycle, unless the queue
// is empty or a result waits stalled, into a registered output. The output
// register and the queue let each side stall on its own.
// Configuration writes are always ready and take effect at once; they belong
// between streams.
module speech_segment_tracker import sst_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        speech_prob_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               seg_valid_o,
  output logic [31:0]        seg_start_o,
  output logic [31:0]        seg_end_o,
  output logic               speaking_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  cfg_t    cfg_q;
  cls_e    in_cls;
  cls_e    q_cls;
  logic    q_empty;
  logic    q_full;
  logic    q_pop;
  logic    in_xfer;
  result_t res;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;
  assign in_xfer     = in_valid_i && !q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prob_threshold    <= 16'd32768;
      cfg_q.window_samples    <= 16'd512;
      cfg_q.min_silence_len   <= 24'd1600;
      cfg_q.min_speech_len    <= 24'd4000;
      cfg_q.max_speech_len    <= 32'hFFFF_FFFF;
      cfg_q.split_silence_len <= 24'd1568;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgProbThreshold:   cfg_q.prob_threshold    <= cfg_data_i[15:0];
        CfgWindowSamples:   cfg_q.window_samples    <= cfg_data_i[15:0];
        CfgMinSilenceLen:   cfg_q.min_silence_len   <= cfg_data_i[23:0];
        CfgMinSpeechLen:    cfg_q.min_speech_len    <= cfg_data_i[23:0];
        CfgMaxSpeechLen:    cfg_q.max_speech_len    <= cfg_data_i;
        CfgSplitSilenceLen: cfg_q.split_silence_len <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  sst_front u_front (
    .speech_prob_i    (speech_prob_i),
    .prob_threshold_i (cfg_q.prob_threshold),
    .cls_o            (in_cls)
  );

  sst_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (in_xfer),
    .wr_cls_i (in_cls),
    .rd_en_i  (q_pop),
    .rd_cls_o (q_cls),
    .empty_o  (q_empty),
    .full_o   (q_full)
  );

  sst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_cls_i     (q_cls),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign seg_valid_o = res.seg_valid;
  assign seg_start_o = res.seg_start;
  assign seg_end_o   = res.seg_end;
  assign speaking_o  = res.speaking;

endmodule

// ===== rtl/sst_checker.sv =====
module sst_checker import sst_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        seg_valid_o,
  input logic [31:0] seg_start_o,
  input logic [31:0] seg_end_o,
  input logic        speaking_o
);

  // a waiting result holds until transferred
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(seg_valid_o) &&
    $stable(seg_start_o) && $stable(seg_end_o) && $stable(speaking_o))
    else $error("stalled result changed");

  // no segment reported means zero bounds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !seg_valid_o |-> seg_start_o == '0 && seg_end_o == '0)
    else $error("bounds set without segment");

  // the queue fills only through an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall without transfer");

  // a result leaves only when transferred
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("result dropped");

endmodule

bind speech_segment_tracker sst_checker u_sst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .seg_valid_o (seg_valid_o),
  .seg_start_o (seg_start_o),
  .seg_end_o   (seg_end_o),
  .speaking_o  (speaking_o)
);

// ===== tb/sv/speech_segment_tracker_tb.sv =====
`timescale 1ns / 100ps

module speech_segment_tracker_tb;
  import sst_pkg::*;

  // indexes past the last register, the block must ignore them
  localparam logic [CfgIdxW-1:0] CfgSpareA = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 3'd7;

  typedef enum {ProbHigh, ProbMid, ProbLow, ProbAny} prob_kind_e;
  typedef enum {RunSpeech, RunSilence, RunNoise} run_e;

  class seg_scoreboard;
    logic [15:0] thr;
    logic [15:0] win;
    logic [23:0] min_sil;
    logic [23:0] min_sp;
    logic [31:0] max_sp;
    logic [23:0] split_sil;

    logic [31:0] pos;
    logic        speaking;
    logic [31:0] sil_from;
    logic [31:0] good_end;
    logic [31:0] resume_at;
    logic [31:0] seg_from;
    logic [31:0] seg_to;

    result_t expected_q[$];
    int      errors;
    int      windows;
    int      segments;

    function new();
      thr       = 16'd32768;
      win       = 16'd512;
      min_sil   = 24'd1600;
      min_sp    = 24'd4000;
      max_sp    = 32'hFFFF_FFFF;
      split_sil = 24'd1568;
      pos       = '0;
      speaking  = 1'b0;
      drop_segment();
      errors    = 0;
      windows   = 0;
      segments  = 0;
    endfunction

    function void drop_segment();
      seg_from  = '0;
      seg_to    = '0;
      good_end  = '0;
      resume_at = '0;
      sil_from  = '0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
      case (idx)
        CfgProbThreshold:   thr       = data[15:0];
        CfgWindowSamples:   win       = data[15:0];
        CfgMinSilenceLen:   min_sil   = data[23:0];
        CfgMinSpeechLen:    min_sp    = data[23:0];
        CfgMaxSpeechLen:    max_sp    = data;
        CfgSplitSilenceLen: split_sil = data[23:0];
        default: ;
      endcase
    endfunction

    function void note_window(logic [15:0] prob);
      logic [31:0] lo;
      logic [31:0] win_start;
      logic [31:0] quiet;
      logic [31:0] nxt;
      logic        resume;
      result_t     want;
      want = '0;
      lo = (thr >= LowMargin) ? thr - LowMargin : '0;
      pos = pos + win;
      win_start = pos - win;
      if (prob >= thr) begin
        if (sil_from != 0) begin
          sil_from = '0;
          if (resume_at < good_end) resume_at = win_start;
        end
        if (!speaking) begin
          speaking = 1'b1;
          seg_from = win_start;
        end
      end else if (speaking && (pos - seg_from) > max_sp) begin
        // forced cut, at the last long pause when there is one
        want.seg_valid = 1'b1;
        want.seg_start = seg_from;
        if (good_end > 0) begin
          resume = !(resume_at < good_end);
          nxt = resume_at;
          want.seg_end = good_end;
          drop_segment();
          if (resume) seg_from = nxt;
          else speaking = 1'b0;
        end else begin
          want.seg_end = pos;
          drop_segment();
          speaking = 1'b0;
        end
      end else if (prob < lo) begin
        if (speaking) begin
          if (sil_from == 0) sil_from = pos;
          quiet = pos - sil_from;
          if (quiet > split_sil) good_end = sil_from;
          if (quiet >= min_sil) begin
            seg_to = sil_from;
            if ((seg_to - seg_from) > min_sp) begin
              want.seg_valid = 1'b1;
              want.seg_start = seg_from;
              want.seg_end = seg_to;
              drop_segment();
              speaking = 1'b0;
            end
          end
        end
      end
      want.speaking = speaking;
      if (want.seg_valid) segments++;
      windows++;
      expected_q.insert(expected_q.size(), want);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("segment result with no window pending");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.seg_valid !== want.seg_valid) begin
        $error("seg_valid: expected %0d, got %0d", want.seg_valid, got.seg_valid);
        errors++;
      end
      if (got.seg_start !== want.seg_start) begin
        $error("seg_start: expected %0d, got %0d", want.seg_start, got.seg_start);
        errors++;
      end
      if (got.seg_end !== want.seg_end) begin
        $error("seg_end: expected %0d, got %0d", want.seg_end, got.seg_end);
        errors++;
      end
      if (got.speaking !== want.speaking) begin
        $error("speaking: expected %0d, got %0d", want.speaking, got.speaking);
        errors++;
      end
    endfunction

    function int waiting();
      return expected_q.size();
    endfunction
  endclass

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic [15:0]        speech_prob_i = '0;
  logic               out_stall_i   = 1'b0;
  logic               cfg_valid_i   = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i   = '0;
  logic [31:0]        cfg_data_i    = '0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic               seg_valid_o;
  logic [31:0]        seg_start_o;
  logic [31:0]        seg_end_o;
  logic               speaking_o;
  logic               cfg_ready_o;

  seg_scoreboard sb = new();

  run_e run_mode      = RunSilence;
  int   run_left      = 0;
  bit   steady        = 1'b0;
  int   settings_seen = 0;

  speech_segment_tracker uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .speech_prob_i (speech_prob_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .seg_valid_o   (seg_valid_o),
    .seg_start_o   (seg_start_o),
    .seg_end_o     (seg_end_o),
    .speaking_o    (speaking_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99, 0) < 26);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(result_t'{seg_valid_o, seg_start_o, seg_end_o, speaking_o});
    end
  end

  function automatic logic [15:0] pick_prob(prob_kind_e k);
    int unsigned lo;
    lo = (sb.thr >= LowMargin) ? sb.thr - LowMargin : 0;
    case (k)
      ProbHigh: return 16'($urandom_range(32'hFFFF, 32'(sb.thr)));
      ProbMid: begin
        if (sb.thr > lo) return 16'($urandom_range(32'(sb.thr) - 1, lo));
      end
      ProbLow: begin
        if (lo > 0) return 16'($urandom_range(lo - 1, 0));
      end
      default: ;
    endcase
    return 16'($urandom_range(32'hFFFF, 0));
  endfunction

  // speech runs and silence runs sized to the current lengths, some noise
  function automatic logic [15:0] next_prob();
    int         r;
    int         win_eff;
    int         sp_cap;
    int         sil_cap;
    prob_kind_e k;
    if (run_left == 0) begin
      win_eff = (sb.win == 0) ? 1 : int'(sb.win);
      sp_cap = 2 * (int'(sb.min_sp) / win_eff) + 4;
      if (sp_cap > 48) sp_cap = 48;
      sil_cap = 2 * (int'(sb.min_sil) / win_eff) + 3;
      if (sil_cap > 24) sil_cap = 24;
      case (run_mode)
        RunSpeech: begin
          run_mode = RunSilence;
          run_left = $urandom_range(sil_cap, 1);
        end
        RunSilence: begin
          if ($urandom_range(99, 0) < 20) begin
            run_mode = RunNoise;
            run_left = $urandom_range(8, 1);
          end else begin
            run_mode = RunSpeech;
            run_left = $urandom_range(sp_cap, 1);
          end
        end
        default: begin
          run_mode = RunSpeech;
          run_left = $urandom_range(sp_cap, 1);
        end
      endcase
    end
    run_left--;
    r = $urandom_range(99, 0);
    case (run_mode)
      RunSpeech:  k = (r < 90) ? ProbHigh : (r < 95) ? ProbMid : ProbLow;
      RunSilence: k = (r < 90) ? ProbLow : (r < 95) ? ProbMid : ProbHigh;
      default:    k = ProbAny;
    endcase
    return pick_prob(k);
  endfunction

  task automatic send_window(logic [15:0] prob);
    @(negedge clk_i);
    while (!steady && $urandom_range(99, 0) < 26) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    speech_prob_i <= prob;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_window(prob);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic load_setting(int k);
    logic [31:0] thr;
    logic [31:0] win;
    logic [31:0] msil;
    logic [31:0] msp;
    logic [31:0] mx;
    logic [31:0] spl;
    case (k)
      0: begin
        thr = 32'hFFFF; win = 32'd1; msil = '0; msp = '0; mx = '0; spl = '0;
      end
      1: begin
        thr = '0; win = 32'hFFFF; msil = 32'hFF_FFFF; msp = 32'hFF_FFFF;
        mx = 32'hFFFF_FFFF; spl = 32'hFF_FFFF;
      end
      2: begin
        // lower threshold saturates at zero, only forced cuts close segments
        thr = 32'd9829; win = 32'hFFFF; msil = 32'd1000; msp = '0;
        mx = 32'hFFFF * 12; spl = '0;
      end
      3: begin
        // position stands still
        thr = 32'd9831; win = '0; msil = '0; msp = '0; mx = '0; spl = '0;
      end
      12: begin
        thr = 32'd32768; win = 32'hFFFF; msil = 32'hFFFF * 3; msp = 32'hFFFF * 6;
        mx = 32'hFFFF * 20; spl = 32'hFFFF * 2;
      end
      default: begin
        thr = $urandom_range(60000, 12000);
        win = ($urandom_range(3, 0) == 0) ? $urandom_range(65535, 1) : $urandom_range(1024, 16);
        msil = win * $urandom_range(6, 0) + $urandom_range(win, 0);
        msp = win * $urandom_range(12, 0) + $urandom_range(win, 0);
        mx = ($urandom_range(2, 0) == 0) ? 32'hFFFF_FFFF : win * $urandom_range(40, 4);
        spl = win * $urandom_range(5, 0) + $urandom_range(win, 0);
        // junk above the register width
        thr  = thr | ($urandom() & 32'hFFFF_0000);
        win  = win | ($urandom() & 32'hFFFF_0000);
        msil = msil | ($urandom() & 32'hFF00_0000);
        msp  = msp | ($urandom() & 32'hFF00_0000);
        spl  = spl | ($urandom() & 32'hFF00_0000);
      end
    endcase
    settle();
    write_reg(CfgProbThreshold, thr);
    write_reg(CfgWindowSamples, win);
    write_reg(CfgMinSilenceLen, msil);
    write_reg(CfgMinSpeechLen, msp);
    write_reg(CfgMaxSpeechLen, mx);
    write_reg(CfgSplitSilenceLen, spl);
    write_reg(CfgSpareA, $urandom());
    write_reg(CfgSpareB, $urandom());
    settings_seen++;
  endtask

  initial begin
    logic [15:0] opening[$] = '{16'h0000, 16'hFFFF, 16'd32768, 16'd32767, 16'd22938,
                                16'd22937, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hAAAA,
                                16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h5555,
                                16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
                                16'h0000, 16'h0000, 16'hFFFF, 16'h0001, 16'h8000};
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (opening[i]) send_window(opening[i]);
    repeat (100) send_window(next_prob());

    for (int k = 0; k < 12; k++) begin
      load_setting(k);
      steady = (k == 6);
      repeat ((k < 4) ? 60 : 110) send_window(next_prob());
    end
    steady = 1'b0;

    // long windows against long lengths
    load_setting(12);
    repeat (40) send_window(next_prob());
    settle();

    $display("covered %0d windows over %0d register settings, stalls on both sides",
             sb.windows, settings_seen + 1);
    $display("%0d segments closed", sb.segments);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sst_pkg.sv
rtl/sst_front.sv
rtl/sst_fifo.sv
rtl/sst_back.sv
rtl/speech_segment_tracker.sv
rtl/sst_checker.sv
tb/sv/speech_segment_tracker_tb.sv
